// File: src/sbm_pkg.sv
// shared types and constants of the serially loaded bank mapper
package sbm_pkg;

  localparam int unsigned REG_W       = 5;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned SEL_W       = 2;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned PRG_W       = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [CNT_W-1:0]   SHIFT_BITS      = 3'd5;
  localparam logic [STAMP_W-1:0] MIN_WRITE_GAP   = 32'd2;
  localparam logic [REG_W-1:0]   CTL_RESET       = 5'h1F;
  localparam logic [REG_W-1:0]   CTL_PRG_FORCE   = 5'h0C;
  localparam logic [PRG_W-1:0]   PRG_LAST_BANK   = 6'h0F;
  localparam logic [PRG_W-1:0]   PRG_OUTER_BLOCK = 6'h10;

  // register select codes
  localparam logic [SEL_W-1:0] SEL_CONTROL = 2'd0;
  localparam logic [SEL_W-1:0] SEL_CHR0    = 2'd1;
  localparam logic [SEL_W-1:0] SEL_CHR1    = 2'd2;
  localparam logic [SEL_W-1:0] SEL_PRG     = 2'd3;

  // prg mode codes, control bits 3:2
  localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'b11;
  localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'b10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_WRAM_DISABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_CONTROL_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_WRAM            = 2'd2;

  typedef struct packed {
    logic [REG_W-1:0] prg;
    logic [REG_W-1:0] chr1;
    logic [REG_W-1:0] chr0;
    logic [REG_W-1:0] control;
  } bank_regs_t;

  typedef struct packed {
    logic large_wram;
    logic mirror_control_enable;
    logic ignore_wram_disable;
  } cfg_t;

  // first field in the highest bits, last field in the lowest bits
  typedef struct packed {
    logic             wram_bank;
    logic             wram_enabled;
    logic             mirroring_driven;
    logic [1:0]       mirroring;
    logic [REG_W-1:0] chr_bank_high;
    logic [REG_W-1:0] chr_bank_low;
    logic [PRG_W-1:0] prg_bank_high;
    logic [PRG_W-1:0] prg_bank_low;
    logic             register_committed;
    logic             write_taken;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// File: src/sbm_regs.sv
// serial shifter, internal mapper registers, write stamp and configuration registers
module sbm_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [sbm_pkg::SEL_W-1:0]       reg_select,
  input  logic [sbm_pkg::DATA_W-1:0]      data,
  input  logic [sbm_pkg::STAMP_W-1:0]     cycle_stamp,
  input  logic                            cfg_we,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                            cfg_data,
  output logic                            write_taken,
  output logic                            register_committed,
  output sbm_pkg::bank_regs_t             regs_nxt,
  output sbm_pkg::cfg_t                   cfg
);
  import sbm_pkg::*;

  logic [REG_W-1:0]   mapper_regs_r [4];
  logic [REG_W-1:0]   mapper_regs_nxt [4];
  logic [REG_W-1:0]   shift_value_r, shift_value_nxt;
  logic [CNT_W-1:0]   shift_count_r, shift_count_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  cfg_t               cfg_r;
  logic [STAMP_W-1:0] stamp_diff;
  logic [REG_W-1:0]   shifted;
  logic [CNT_W-1:0]   count_inc;

  assign stamp_diff = cycle_stamp - stamp_r;
  assign shifted    = shift_value_r | (REG_W'(data[0]) << shift_count_r);
  assign count_inc  = shift_count_r + CNT_W'(1);

  always_comb begin
    mapper_regs_nxt    = mapper_regs_r;
    shift_value_nxt    = shift_value_r;
    shift_count_nxt    = shift_count_r;
    stamp_nxt          = stamp_r;
    write_taken        = 1'b0;
    register_committed = 1'b0;
    if (stamp_diff >= MIN_WRITE_GAP) begin
      write_taken = 1'b1;
      if (data[DATA_W-1]) begin
        mapper_regs_nxt[SEL_CONTROL] = mapper_regs_r[SEL_CONTROL] | CTL_PRG_FORCE;
        shift_value_nxt              = '0;
        shift_count_nxt              = '0;
        stamp_nxt                    = cycle_stamp;
      end else if (count_inc >= SHIFT_BITS) begin
        mapper_regs_nxt[reg_select] = shifted;
        shift_value_nxt             = '0;
        shift_count_nxt             = '0;
        register_committed          = 1'b1;
      end else begin
        shift_value_nxt = shifted;
        shift_count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapper_regs_r[SEL_CONTROL] <= CTL_RESET;
      mapper_regs_r[SEL_CHR0]    <= '0;
      mapper_regs_r[SEL_CHR1]    <= '0;
      mapper_regs_r[SEL_PRG]     <= '0;
      shift_value_r              <= '0;
      shift_count_r              <= '0;
      stamp_r                    <= '0;
    end else if (accept) begin
      mapper_regs_r <= mapper_regs_nxt;
      shift_value_r <= shift_value_nxt;
      shift_count_r <= shift_count_nxt;
      stamp_r       <= stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ignore_wram_disable   <= 1'b0;
      cfg_r.mirror_control_enable <= 1'b1;
      cfg_r.large_wram            <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IGNORE_WRAM_DISABLE:   cfg_r.ignore_wram_disable   <= cfg_data;
        CFG_MIRROR_CONTROL_ENABLE: cfg_r.mirror_control_enable <= cfg_data;
        CFG_LARGE_WRAM:            cfg_r.large_wram            <= cfg_data;
        default: ;
      endcase
    end
  end

  assign regs_nxt.control = mapper_regs_nxt[SEL_CONTROL];
  assign regs_nxt.chr0    = mapper_regs_nxt[SEL_CHR0];
  assign regs_nxt.chr1    = mapper_regs_nxt[SEL_CHR1];
  assign regs_nxt.prg     = mapper_regs_nxt[SEL_PRG];
  assign cfg              = cfg_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    shift_count_r < SHIFT_BITS)
    else $error("shift count out of range");

  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && register_committed |=> shift_count_r == '0 && shift_value_r == '0)
    else $error("shifter not cleared after commit");

  a_too_soon_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !write_taken |=> $stable(shift_count_r) && $stable(stamp_r)
      && $stable(shift_value_r))
    else $error("ignored write changed state");

  a_commit_taken: assert property (@(posedge clk) disable iff (!rst_n)
    register_committed |-> write_taken && !data[DATA_W-1])
    else $error("commit on ignored or reset write");
endmodule

// File: src/sbm_report.sv
// bank mapping decode from the internal registers and configuration
module sbm_report (
  input  logic                  write_taken,
  input  logic                  register_committed,
  input  sbm_pkg::bank_regs_t   regs,
  input  sbm_pkg::cfg_t         cfg,
  output sbm_pkg::result_t      result
);
  import sbm_pkg::*;

  logic [PRG_W-1:0] offs;
  logic [PRG_W-1:0] prg_full;
  logic [PRG_W-1:0] prg_base;

  assign offs     = regs.chr0[4] ? PRG_OUTER_BLOCK : '0;
  assign prg_full = PRG_W'(regs.prg) + offs;
  assign prg_base = PRG_W'({regs.prg[REG_W-1:1], 1'b0}) + offs;

  always_comb begin
    result                    = '0;
    result.write_taken        = write_taken;
    result.register_committed = register_committed;
    case (regs.control[3:2])
      PRG_MODE_FIX_HIGH: begin
        result.prg_bank_low  = prg_full;
        result.prg_bank_high = PRG_LAST_BANK + offs;
      end
      PRG_MODE_FIX_LOW: begin
        result.prg_bank_low  = offs;
        result.prg_bank_high = prg_full;
      end
      default: begin
        result.prg_bank_low  = prg_base;
        result.prg_bank_high = prg_base + PRG_W'(1);
      end
    endcase
    if (regs.control[4]) begin
      result.chr_bank_low  = regs.chr0;
      result.chr_bank_high = regs.chr1;
    end else begin
      result.chr_bank_low  = {regs.chr0[REG_W-1:1], 1'b0};
      result.chr_bank_high = {regs.chr0[REG_W-1:1], 1'b1};
    end
    result.mirroring        = cfg.mirror_control_enable ? regs.control[1:0] : 2'b00;
    result.mirroring_driven = cfg.mirror_control_enable;
    result.wram_enabled     = !regs.prg[4] || cfg.ignore_wram_disable;
    if (cfg.large_wram) begin
      result.wram_bank = regs.control[4] ? regs.chr0[4] : regs.chr0[3];
    end else begin
      result.wram_bank = 1'b0;
    end
  end
endmodule

// File: src/serial_loaded_bank_mapper_top.sv
// serially loaded bank mapper: top level with stream handshake and result register
//
// in channel: one word per cpu write to the mapper range (register select,
// data byte, cycle stamp). out channel: one word per accepted input word with
// the write status and the bank mapping after that write.
// cfg channel: writes one configuration register per handshake, cfg_ready is
// always high; write it only while no word is in flight.
// latency: the result of a word accepted at one edge is on out_tdata with
// out_tvalid high from the next cycle on.
// throughput: one word per cycle while out_tready is high; the shifter and
// register update is one short pass of logic ahead of the result register.
// a word is taken whenever the result register is empty or is being read in
// the same cycle, so a stalled receiver holds in_tready low until it takes
// the pending result; nothing is dropped.
// reset: control register reads 0x1f, the other mapper registers, the shifter and
// the write stamp clear, mirroring is driven and the result register is empty.
module serial_loaded_bank_mapper_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // reg_select[1:0], data[9:2], cycle_stamp[41:10], zero fill
  input  logic [sbm_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // write_taken[0], register_committed[1], prg_bank_low[7:2], prg_bank_high[13:8],
  // chr_bank_low[18:14], chr_bank_high[23:19], mirroring[25:24],
  // mirroring_driven[26], wram_enabled[27], wram_bank[28], zero fill
  output logic [sbm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic                                cfg_data
);
  import sbm_pkg::*;

  logic       in_accept;
  logic       write_taken;
  logic       register_committed;
  bank_regs_t regs_nxt;
  cfg_t       cfg;
  result_t    result;
  result_t    result_r;
  logic       out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  sbm_regs u_regs (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (in_accept),
    .reg_select         (in_tdata[SEL_W-1:0]),
    .data               (in_tdata[SEL_W+DATA_W-1:SEL_W]),
    .cycle_stamp        (in_tdata[SEL_W+DATA_W+STAMP_W-1:SEL_W+DATA_W]),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .write_taken        (write_taken),
    .register_committed (register_committed),
    .regs_nxt           (regs_nxt),
    .cfg                (cfg)
  );

  sbm_report u_report (
    .write_taken        (write_taken),
    .register_committed (register_committed),
    .regs               (regs_nxt),
    .cfg                (cfg),
    .result             (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(result_r);

  a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_tvalid)
    else $error("accepted word produced no result");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("word accepted over pending result");

  a_pending_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(result_r))
    else $error("pending result lost");
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// testbench of the serially loaded bank mapper: stream traffic against a scoreboard predictor
module tb;
  import sbm_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned PHASES = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  class bank_map_scoreboard;
    logic [REG_W-1:0] regs [4];
    logic [REG_W-1:0] shift_val;
    logic [CNT_W-1:0] shift_cnt;
    logic [STAMP_W-1:0] reset_stamp;
    cfg_t cfg;
    result_t mapping_q [$];
    int errors;

    function new();
      regs[SEL_CONTROL] = CTL_RESET;
      regs[SEL_CHR0] = '0;
      regs[SEL_CHR1] = '0;
      regs[SEL_PRG] = '0;
      shift_val = '0;
      shift_cnt = '0;
      reset_stamp = '0;
      cfg.ignore_wram_disable = 1'b0;
      cfg.mirror_control_enable = 1'b1;
      cfg.large_wram = 1'b0;
      errors = 0;
    endfunction

    function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic val);
      case (idx)
        CFG_IGNORE_WRAM_DISABLE: cfg.ignore_wram_disable = val;
        CFG_MIRROR_CONTROL_ENABLE: cfg.mirror_control_enable = val;
        CFG_LARGE_WRAM: cfg.large_wram = val;
        default: ;
      endcase
    endfunction

    function result_t mapping(logic taken, logic committed);
      result_t r;
      logic [REG_W-1:0] ctl, c0, c1;
      logic [PRG_W-1:0] pr, offs, base;
      ctl = regs[SEL_CONTROL];
      c0 = regs[SEL_CHR0];
      c1 = regs[SEL_CHR1];
      pr = {1'b0, regs[SEL_PRG]};
      offs = c0[4] ? PRG_OUTER_BLOCK : '0;
      r = '0;
      r.write_taken = taken;
      r.register_committed = committed;
      case (ctl[3:2])
        PRG_MODE_FIX_HIGH: begin
          r.prg_bank_low = pr + offs;
          r.prg_bank_high = PRG_LAST_BANK + offs;
        end
        PRG_MODE_FIX_LOW: begin
          r.prg_bank_low = offs;
          r.prg_bank_high = pr + offs;
        end
        default: begin
          base = {pr[PRG_W-1:1], 1'b0} + offs;
          r.prg_bank_low = base;
          r.prg_bank_high = base + 1'b1;
        end
      endcase
      if (ctl[4]) begin
        r.chr_bank_low = c0;
        r.chr_bank_high = c1;
      end else begin
        r.chr_bank_low = {c0[4:1], 1'b0};
        r.chr_bank_high = {c0[4:1], 1'b1};
      end
      r.mirroring = cfg.mirror_control_enable ? ctl[1:0] : 2'b00;
      r.mirroring_driven = cfg.mirror_control_enable;
      r.wram_enabled = !pr[4] || cfg.ignore_wram_disable;
      if (cfg.large_wram)
        r.wram_bank = ctl[4] ? c0[4] : c0[3];
      else
        r.wram_bank = 1'b0;
      return r;
    endfunction

    function void note_write(logic [SEL_W-1:0] sel, logic [DATA_W-1:0] data,
                             logic [STAMP_W-1:0] stamp);
      logic [STAMP_W-1:0] since_reset;
      logic committed;
      since_reset = stamp - reset_stamp;
      committed = 1'b0;
      if (since_reset < MIN_WRITE_GAP) begin
        mapping_q.push_back(mapping(1'b0, 1'b0));
      end else if (data[7]) begin
        regs[SEL_CONTROL] = regs[SEL_CONTROL] | CTL_PRG_FORCE;
        shift_val = '0;
        shift_cnt = '0;
        reset_stamp = stamp;
        mapping_q.push_back(mapping(1'b1, 1'b0));
      end else begin
        shift_val[shift_cnt] = data[0];
        shift_cnt = shift_cnt + 1'b1;
        if (shift_cnt == SHIFT_BITS) begin
          regs[sel] = shift_val;
          shift_val = '0;
          shift_cnt = '0;
          committed = 1'b1;
        end
        mapping_q.push_back(mapping(1'b1, committed));
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (mapping_q.size() == 0) begin
        $error("result word %h with no write pending", got);
        errors++;
        return;
      end
      want = mapping_q.pop_front();
      check_field("write_taken", 8'(want.write_taken), 8'(got.write_taken));
      check_field("register_committed", 8'(want.register_committed),
                  8'(got.register_committed));
      check_field("prg_bank_low", 8'(want.prg_bank_low), 8'(got.prg_bank_low));
      check_field("prg_bank_high", 8'(want.prg_bank_high), 8'(got.prg_bank_high));
      check_field("chr_bank_low", 8'(want.chr_bank_low), 8'(got.chr_bank_low));
      check_field("chr_bank_high", 8'(want.chr_bank_high), 8'(got.chr_bank_high));
      check_field("mirroring", 8'(want.mirroring), 8'(got.mirroring));
      check_field("mirroring_driven", 8'(want.mirroring_driven), 8'(got.mirroring_driven));
      check_field("wram_enabled", 8'(want.wram_enabled), 8'(got.wram_enabled));
      check_field("wram_bank", 8'(want.wram_bank), 8'(got.wram_bank));
    endfunction

    function int pending();
      return mapping_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic cfg_data;

  bank_map_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned item_count = 0;
  bit quiet = 1'b0;
  logic [STAMP_W-1:0] stamp_now = '0;

  serial_loaded_bank_mapper_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(result_t'(out_tdata[RESULT_W-1:0]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // receiver with random stalls
  initial begin
    int unsigned stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0)
          stall = pick_gap();
      end
    end
  end

  task automatic send_write(logic [SEL_W-1:0] sel, logic [DATA_W-1:0] data,
                            logic [STAMP_W-1:0] stamp);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({stamp, data, sel});
    do @(posedge clk); while (!in_tready);
    sb.note_write(sel, data, stamp);
    stamp_now = stamp;
    item_count++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_config(cfg_t vals, bit stray);
    logic [CFG_IDX_W-1:0] idx [4];
    logic val [4];
    int n;
    idx = '{CFG_IGNORE_WRAM_DISABLE, CFG_MIRROR_CONTROL_ENABLE, CFG_LARGE_WRAM, CFG_UNUSED};
    val = '{vals.ignore_wram_disable, vals.mirror_control_enable, vals.large_wram,
            1'($urandom)};
    n = stray ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_cfg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic load_reg(logic [SEL_W-1:0] sel, logic [REG_W-1:0] value);
    logic [SEL_W-1:0] s;
    for (int i = 0; i < REG_W; i++) begin
      s = (i == REG_W - 1) ? sel : SEL_W'($urandom);
      send_write(s, {1'b0, 6'($urandom), value[i]}, stamp_now + 1'b1);
    end
  endtask

  task automatic write_sequence();
    logic [STAMP_W-1:0] first;
    if ($urandom_range(0, 1)) begin
      send_write(SEL_W'($urandom), 8'h80 | DATA_W'($urandom_range(0, 127)),
                 stamp_now + $urandom_range(2, 6));
      first = stamp_now + (($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 4));
    end else begin
      first = stamp_now + $urandom_range(1, 3);
    end
    for (int i = 0; i < REG_W; i++)
      send_write(SEL_W'($urandom), DATA_W'($urandom_range(0, 127)),
                 (i == 0) ? first : stamp_now + $urandom_range(1, 3));
  endtask

  task automatic noise_write();
    logic [STAMP_W-1:0] stamp;
    case ($urandom_range(0, 3))
      0: stamp = sb.reset_stamp + $urandom_range(0, 1);
      1: stamp = $urandom;
      default: stamp = stamp_now + $urandom_range(1, 3);
    endcase
    send_write(SEL_W'($urandom), DATA_W'($urandom), stamp);
  endtask

  initial begin
    cfg_t vals;
    int unsigned start;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stamps 0 and 1 fall too soon after reset, even a reset write
    send_write(SEL_CONTROL, 8'h01, 32'd0);
    send_write(SEL_PRG, 8'h80, 32'd1);
    send_write(SEL_CHR1, 8'hFF, 32'd2);
    send_write(SEL_CHR0, 8'h01, 32'd3);
    // full prg with outer block, then 8k chr with fixed low bank
    load_reg(SEL_PRG, 5'h1F);
    load_reg(SEL_CHR0, 5'h1F);
    load_reg(SEL_CONTROL, 5'h0A);
    // stamp difference wraps around zero
    send_write(SEL_CONTROL, 8'hC0, 32'hFFFF_FFFF);
    send_write(SEL_CHR1, 8'hFE, 32'h0000_0000);
    send_write(SEL_PRG, 8'h7F, 32'h0000_0001);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          vals.ignore_wram_disable = 1'b1;
          vals.mirror_control_enable = 1'b0;
          vals.large_wram = 1'b1;
        end
        1: vals = '0;
        2: vals = '1;
        default: vals = cfg_t'($urandom);
      endcase
      load_config(vals, ph == 0 || $urandom_range(0, 1) == 1);
      quiet = (ph == 2);
      start = item_count;
      while (item_count - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 70)
          write_sequence();
        else
          noise_write();
      end
    end

    drain();
    repeat (3) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
